// ===== src/rfp_pkg.sv =====
// Package: item types, phase encoding and frame constants for the reply frame parser.
`timescale 1ns / 1ps
`default_nettype none

package rfp_pkg;

   localparam int DEFAULT_MAX_CAPACITY = 32;
   localparam int CAPACITY_W            = 6;
   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 6'd32;

   localparam logic [7:0] MARK_BEGIN = 8'hE0;
   localparam logic [7:0] MARK_END   = 8'hEE;
   localparam logic [7:0] REPLY_BIT  = 8'h80;
   localparam logic [6:0] OP_MASK    = 7'h7F;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_BYTE  = 1'b1;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_BAD_OP = 2'd2;
   localparam logic [1:0] KIND_BAD_END = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_WAIT_BEGIN = 3'd1,
      PH_OPCODE     = 3'd2,
      PH_COUNT      = 3'd3,
      PH_LEN        = 3'd4,
      PH_DATA       = 3'd5,
      PH_END        = 3'd6
   } phase_type;

   typedef struct packed {
      logic       func;
      logic [6:0] expected_op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [4:0] index;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/rfp_in_stage.sv =====
// Input register: holds one request item until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none

module rfp_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rfp_pkg::req_type req_item,
   input  wire logic             advance,
   output logic                  item_valid,
   output rfp_pkg::req_type      item
);
   import rfp_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    accept;

   assign req_stall  = valid_ff & ~advance;
   assign accept     = req_valid & ~req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/rfp_parser.sv =====
// Frame parser: phase and counter registers with the per-byte next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module rfp_parser #(
   parameter int MAX_CAPACITY = rfp_pkg::DEFAULT_MAX_CAPACITY
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire rfp_pkg::req_type                item,
   input  wire logic [rfp_pkg::CAPACITY_W-1:0]  capacity,
   output logic                                 res_valid,
   output rfp_pkg::rsp_type                     res
);
   import rfp_pkg::*;

   localparam int CW   = $clog2(MAX_CAPACITY + 1);
   localparam int CMPW = (CW > CAPACITY_W) ? CW : CAPACITY_W;

   phase_type     phase_ff, phase_in;
   logic [6:0]    op_ff, op_in;
   logic [7:0]    params_ff, params_in;
   logic [7:0]    pbytes_ff, pbytes_in;
   logic [CW-1:0] space_ff, space_in;
   logic [CW-1:0] wpos_ff, wpos_in;

   logic [CMPW-1:0] cap_ext, max_ext, cap_sat;
   logic [7:0]      b, params_dec, pbytes_dec;

   assign cap_ext = CMPW'(capacity);
   assign max_ext = CMPW'(MAX_CAPACITY);
   assign cap_sat = (cap_ext > max_ext) ? max_ext : cap_ext;
   assign b       = item.rx_byte;

   always_comb begin
      phase_in   = phase_ff;
      op_in      = op_ff;
      params_in  = params_ff;
      pbytes_in  = pbytes_ff;
      space_in   = space_ff;
      wpos_in    = wpos_ff;
      res_valid  = 1'b0;
      res        = '0;
      params_dec = (params_ff == 8'd0) ? 8'd0 : params_ff - 8'd1;
      pbytes_dec = (pbytes_ff == 8'd0) ? 8'd0 : pbytes_ff - 8'd1;

      if (item.func == FUNC_START) begin
         op_in     = item.expected_op & OP_MASK;
         phase_in  = PH_WAIT_BEGIN;
         params_in = 8'd0;
         pbytes_in = 8'd0;
         space_in  = CW'(cap_sat);
         wpos_in   = '0;
      end else begin
         case (phase_ff)
            PH_WAIT_BEGIN: begin
               if (b == MARK_BEGIN) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_OPCODE: begin
               if (b == ({1'b0, op_ff} | REPLY_BIT)) begin
                  phase_in = PH_COUNT;
               end else begin
                  phase_in  = PH_IDLE;
                  res_valid = 1'b1;
                  res.kind  = KIND_BAD_OP;
               end
            end
            PH_COUNT: begin
               params_in = b;
               phase_in  = (b == 8'd0) ? PH_END : PH_LEN;
            end
            PH_LEN: begin
               pbytes_in = b;
               if (b == 8'd0) begin
                  params_in = params_dec;
                  phase_in  = (params_dec == 8'd0) ? PH_END : PH_LEN;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               if (space_ff != '0) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_DATA;
                  res.data  = b;
                  res.index = 5'(wpos_ff);
                  wpos_in   = wpos_ff + CW'(1);
                  space_in  = space_ff - CW'(1);
               end
               pbytes_in = pbytes_dec;
               if (pbytes_dec == 8'd0) begin
                  params_in = params_dec;
                  phase_in  = (params_dec == 8'd0) ? PH_END : PH_LEN;
               end
            end
            PH_END: begin
               phase_in  = PH_IDLE;
               res_valid = 1'b1;
               res.kind  = (b == MARK_END) ? KIND_DONE : KIND_BAD_END;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         op_ff     <= '0;
         params_ff <= '0;
         pbytes_ff <= '0;
         space_ff  <= '0;
         wpos_ff   <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         op_ff     <= op_in;
         params_ff <= params_in;
         pbytes_ff <= pbytes_in;
         space_ff  <= space_in;
         wpos_ff   <= wpos_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/rfp_out_stage.sv =====
// Output register: holds one result item until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module rfp_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             item_valid,
   input  wire logic             res_valid,
   input  wire rfp_pkg::rsp_type res,
   output logic                  advance,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rfp_pkg::rsp_type      rsp_item
);
   import rfp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff;
   logic    free;
   logic    load;

   assign free      = ~valid_ff | ~rsp_stall;
   assign advance   = item_valid & free;
   assign load      = advance & res_valid;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_comb begin
      if (free) begin
         valid_in = load;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= res;
      end
   end

endmodule

`default_nettype wire

// ===== src/module_reply_frame_parser.sv =====
// Top level: reply frame parser with capacity register, input and output registers.
`timescale 1ns / 1ps
`default_nettype none

// Parses a wireless module's serial reply frame one received byte per item. A start
// item (func 0) arms the parser with the sent opcode and loads the buffer space from
// the capacity register, saturated to MAX_CAPACITY; a capacity write takes effect at
// the next start item. Byte items (func 1) then yield at most one result each: a
// stored data byte with its buffer index, frame done, wrong reply opcode or bad end
// marker. One item is taken every cycle while no stalled result holds the parser; an
// item passes through the input register, then the result register, before its result
// is presented, and a stalled result holds the parser while the input register
// still takes one further item. No start-up sweep.
module module_reply_frame_parser #(
   parameter int MAX_CAPACITY = rfp_pkg::DEFAULT_MAX_CAPACITY
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire rfp_pkg::req_type                req_item,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output rfp_pkg::rsp_type                     rsp_item,
   input  wire logic                            csr_wr_en,
   input  wire logic [rfp_pkg::CAPACITY_W-1:0]  csr_wr_data
);
   import rfp_pkg::*;

   logic [CAPACITY_W-1:0] capacity_ff;
   logic                  advance;
   logic                  item_valid;
   req_type               item;
   logic                  res_valid;
   rsp_type               res;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   rfp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   rfp_parser #(
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .capacity  (capacity_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   rfp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .res_valid  (res_valid),
      .res        (res),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the reply frame parser: directed table, then random frames checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
   import rfp_pkg::*;

   localparam int MAX_CAP          = DEFAULT_MAX_CAPACITY;
   localparam int ITEMS_PER_PHASE  = 170;
   localparam int FRAME_MAX        = 80;
   localparam int DRAIN_CYCLES     = 8;
   localparam int CYCLE_LIMIT      = 400000;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_RESULT
   } row_check_type;

   typedef struct packed {
      row_check_type chk;
      req_type       item;
      rsp_type       want;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_item;
   logic                  csr_wr_en = 1'b0;
   logic [CAPACITY_W-1:0] csr_wr_data = '0;

   int                    cycles = 0;
   int                    errors = 0;
   int                    send_pct = 0;
   int                    recv_pct = 0;
   rsp_type               owed_results [$];
   req_type               frame_items [$];

   // predictor state
   logic [CAPACITY_W-1:0] capacity_reg = CAPACITY_RESET;
   phase_type             frame_phase = PH_IDLE;
   logic [6:0]            armed_op = '0;
   logic [7:0]            params_left = '0;
   logic [7:0]            bytes_left = '0;
   logic [CAPACITY_W-1:0] space_left = '0;
   logic [8:0]            write_pos = '0;

   dir_row_type dir_rows [27] = '{
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'hE0}, '0},
      '{CHK_NONE,   {FUNC_START, 7'h7F, 8'h00}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'h12}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'hE0}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'hFF}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'h02}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'h01}, '0},
      '{CHK_RESULT, {FUNC_BYTE,  7'h00, 8'hFF}, {KIND_DATA, 8'hFF, 5'd0}},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'h00}, '0},
      '{CHK_RESULT, {FUNC_BYTE,  7'h00, 8'hEE}, {KIND_DONE, 8'h00, 5'd0}},
      '{CHK_NONE,   {FUNC_START, 7'h00, 8'hFF}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h7F, 8'hE0}, '0},
      '{CHK_RESULT, {FUNC_BYTE,  7'h00, 8'h81}, {KIND_BAD_OP, 8'h00, 5'd0}},
      '{CHK_NONE,   {FUNC_START, 7'h00, 8'h00}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'hE0}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'h80}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'h00}, '0},
      '{CHK_RESULT, {FUNC_BYTE,  7'h00, 8'h00}, {KIND_BAD_END, 8'h00, 5'd0}},
      '{CHK_NONE,   {FUNC_START, 7'h55, 8'hFF}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h2A, 8'hE0}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'hD5}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'hFF}, '0},
      '{CHK_NONE,   {FUNC_BYTE,  7'h00, 8'hFF}, '0},
      '{CHK_RESULT, {FUNC_BYTE,  7'h00, 8'h00}, {KIND_DATA, 8'h00, 5'd0}},
      '{CHK_MODEL,  {FUNC_BYTE,  7'h00, 8'h3C}, '0},
      '{CHK_NONE,   {FUNC_START, 7'h2A, 8'h00}, '0},
      '{CHK_MODEL,  {FUNC_BYTE,  7'h00, 8'h00}, '0}
   };

   module_reply_frame_parser #(
      .MAX_CAPACITY(MAX_CAP)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_pct);
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycles, what);
      errors++;
   endtask

   always @(posedge clock) begin : check_results
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected item kind %0d data %02h index %0d",
                                    rsp_item.kind, rsp_item.data, rsp_item.index));
         end else begin
            w = owed_results.pop_front();
            if (rsp_item.kind != w.kind)
               flag_mismatch($sformatf("kind %0d, want %0d", rsp_item.kind, w.kind));
            if (rsp_item.data != w.data)
               flag_mismatch($sformatf("data %02h, want %02h", rsp_item.data, w.data));
            if (rsp_item.index != w.index)
               flag_mismatch($sformatf("index %0d, want %0d", rsp_item.index, w.index));
         end
      end
   end

   function automatic void close_param();
      if (params_left != 0)
         params_left--;
      frame_phase = (params_left == 0) ? PH_END : PH_LEN;
   endfunction

   // Advances the parser state by one item; returns 1 when a result is due.
   function automatic bit parse_item(input req_type it, output rsp_type r);
      bit hit;
      hit = 1'b0;
      r = '0;
      if (it.func == FUNC_START) begin
         armed_op    = it.expected_op;
         frame_phase = PH_WAIT_BEGIN;
         params_left = '0;
         bytes_left  = '0;
         space_left  = (capacity_reg > MAX_CAP) ? CAPACITY_W'(MAX_CAP) : capacity_reg;
         write_pos   = '0;
         return 1'b0;
      end
      case (frame_phase)
         PH_WAIT_BEGIN: begin
            if (it.rx_byte == MARK_BEGIN)
               frame_phase = PH_OPCODE;
         end
         PH_OPCODE: begin
            if (it.rx_byte == ({1'b0, armed_op} | REPLY_BIT)) begin
               frame_phase = PH_COUNT;
            end else begin
               frame_phase = PH_IDLE;
               hit = 1'b1;
               r.kind = KIND_BAD_OP;
            end
         end
         PH_COUNT: begin
            params_left = it.rx_byte;
            frame_phase = (it.rx_byte == 0) ? PH_END : PH_LEN;
         end
         PH_LEN: begin
            bytes_left = it.rx_byte;
            if (it.rx_byte == 0)
               close_param();
            else
               frame_phase = PH_DATA;
         end
         PH_DATA: begin
            if (space_left != 0) begin
               hit = 1'b1;
               r.kind  = KIND_DATA;
               r.data  = it.rx_byte;
               r.index = write_pos[4:0];
               write_pos++;
               space_left--;
            end
            if (bytes_left != 0)
               bytes_left--;
            if (bytes_left == 0)
               close_param();
         end
         PH_END: begin
            frame_phase = PH_IDLE;
            hit = 1'b1;
            r.kind = (it.rx_byte == MARK_END) ? KIND_DONE : KIND_BAD_END;
         end
         default: begin
            frame_phase = PH_IDLE;
         end
      endcase
      return hit;
   endfunction

   function automatic req_type make_req(input logic f, input logic [6:0] op,
                                        input logic [7:0] b);
      return {f, op, b};
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      frame_items.push_back(make_req(FUNC_BYTE, 7'($urandom_range(127)), b));
   endfunction

   task automatic send_item(input req_type it, input row_check_type chk, input rsp_type want);
      rsp_type r;
      bit      hit;
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      hit = parse_item(it, r);
      if (chk == CHK_RESULT)
         owed_results.push_back(want);
      else if (chk == CHK_MODEL && hit)
         owed_results.push_back(r);
   endtask

   task automatic write_capacity(input logic [CAPACITY_W-1:0] value);
      req_valid <= 1'b0;
      while (owed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      capacity_reg = value;
   endtask

   // Mostly well-formed frames with random content; some noise, some broken frames.
   task automatic build_frame();
      logic [6:0] op;
      int         n_params;
      int         len;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(4, 1))
            frame_items.push_back(make_req(1'($urandom_range(1)), 7'($urandom_range(127)),
                                           8'($urandom_range(255))));
         return;
      end
      op = 7'($urandom_range(127));
      frame_items.push_back(make_req(FUNC_START, op, 8'($urandom_range(255))));
      repeat ($urandom_range(2))
         put_byte(8'($urandom_range(255)));
      put_byte(MARK_BEGIN);
      put_byte(($urandom_range(99) < 92) ? {1'b1, op} : 8'($urandom_range(255)));
      n_params = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(255);
      put_byte(8'(n_params));
      for (int i = 0; i < n_params && frame_items.size() < FRAME_MAX; i++) begin
         len = ($urandom_range(99) < 88) ? $urandom_range(6) : $urandom_range(255);
         put_byte(8'(len));
         for (int j = 0; j < len && frame_items.size() < FRAME_MAX; j++)
            put_byte(8'($urandom_range(255)));
      end
      if (frame_items.size() < FRAME_MAX)
         put_byte(($urandom_range(99) < 85) ? MARK_END : 8'($urandom_range(255)));
   endtask

   logic [CAPACITY_W-1:0] cap_plan [8] = '{6'd0, 6'd63, 6'd32, 6'd1, 6'd33, 6'd17, 6'd5, 6'd31};

   initial begin
      req_type it;
      int      sent;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[k])
         send_item(dir_rows[k].item, dir_rows[k].chk, dir_rows[k].want);

      for (int p = 0; p < 8; p++) begin
         write_capacity((p == 5) ? CAPACITY_W'($urandom_range(63)) : cap_plan[p]);
         case (p % 4)
            0: begin send_pct = 0;  recv_pct = 0;  end
            1: begin send_pct = 46; recv_pct = 0;  end
            2: begin send_pct = 0;  recv_pct = 46; end
            default: begin send_pct = 36; recv_pct = 36; end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (frame_items.size() == 0)
               build_frame();
            it = frame_items.pop_front();
            if (!(frame_phase == PH_IDLE && it.func == FUNC_BYTE))
               sent++;
            send_item(it, CHK_MODEL, '0);
         end
         frame_items.delete();
      end

      req_valid <= 1'b0;
      while (owed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
